// ===== rtl/arc_pkg.sv =====
// shared types, constants and register codes for the axis rest offset calibrator
package arc_pkg;

  // default number of per-channel state entries
  localparam int unsigned ChannelsDefault = 16;

  // field widths
  localparam int unsigned ChanW   = 4;
  localparam int unsigned SampleW = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned SettleW = 16;
  localparam int unsigned LimitW  = 15;

  // width used to compare a channel number against the channel count (up to 127)
  localparam int unsigned ChCmpW = 7;

  // apb port
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // register reset values
  localparam logic               EnableRst    = 1'b1;
  localparam logic [SettleW-1:0] SettleRst    = 16'd1000;
  localparam logic [LimitW-1:0]  LimitRst     = 15'd13107;
  localparam logic [TimeW-1:0]   WindowEndRst = 32'd3000;

  // register index codes
  typedef enum logic [1:0] {
    REG_ENABLE     = 2'd0,
    REG_SETTLE     = 2'd1,
    REG_MAG_LIMIT  = 2'd2,
    REG_WINDOW_END = 2'd3
  } cfg_reg_e;

  // configuration as seen by the datapath
  typedef struct packed {
    logic               enable;
    logic [SettleW-1:0] settle_time_ms;
    logic [LimitW-1:0]  magnitude_limit;
    logic [TimeW-1:0]   window_end_ms;
  } cfg_t;

  // one channel's calibration state
  typedef struct packed {
    logic                      probe_flag;
    logic [TimeW-1:0]          probe_start;
    logic signed [SampleW-1:0] rest_offset;
    logic signed [SampleW-1:0] last_sample;
  } chan_t;

endpackage

// ===== rtl/arc_cfg_regs.sv =====
// apb configuration registers of the calibrator
module arc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [arc_pkg::AddrW-1:0]   paddr,
  input  logic [arc_pkg::DataW-1:0]   pwdata,
  output logic [arc_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output arc_pkg::cfg_t               cfg_o
);

  arc_pkg::cfg_t     cfg_q;
  arc_pkg::cfg_reg_e sel;
  logic              wr_en;

  assign sel    = arc_pkg::cfg_reg_e'(paddr[arc_pkg::AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable          <= arc_pkg::EnableRst;
      cfg_q.settle_time_ms  <= arc_pkg::SettleRst;
      cfg_q.magnitude_limit <= arc_pkg::LimitRst;
      cfg_q.window_end_ms   <= arc_pkg::WindowEndRst;
    end else if (wr_en) begin
      case (sel)
        arc_pkg::REG_ENABLE:     cfg_q.enable          <= pwdata[0];
        arc_pkg::REG_SETTLE:     cfg_q.settle_time_ms  <= pwdata[arc_pkg::SettleW-1:0];
        arc_pkg::REG_MAG_LIMIT:  cfg_q.magnitude_limit <= pwdata[arc_pkg::LimitW-1:0];
        arc_pkg::REG_WINDOW_END: cfg_q.window_end_ms   <= pwdata[arc_pkg::TimeW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (sel)
      arc_pkg::REG_ENABLE:     prdata = {31'd0, cfg_q.enable};
      arc_pkg::REG_SETTLE:     prdata = {16'd0, cfg_q.settle_time_ms};
      arc_pkg::REG_MAG_LIMIT:  prdata = {17'd0, cfg_q.magnitude_limit};
      arc_pkg::REG_WINDOW_END: prdata = cfg_q.window_end_ms;
      default:                 prdata = '0;
    endcase
  end

endmodule

// ===== rtl/arc_chan_state.sv =====
// per-channel calibration state: one read port, one write port
module arc_chan_state #(
  parameter int unsigned CHANNELS = arc_pkg::ChannelsDefault
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_idx_i,
  output arc_pkg::chan_t                            rd_data_o,
  input  logic                                      wr_en_i,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_idx_i,
  input  arc_pkg::chan_t                            wr_data_i
);

  arc_pkg::chan_t state_q [CHANNELS];

  // all entries clear on reset, one entry written per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        state_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      state_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign rd_data_o = state_q[rd_idx_i];

endmodule

// ===== rtl/arc_calc.sv =====
// probe / latch decision and offset correction for one sample
module arc_calc (
  input  arc_pkg::cfg_t                       cfg_i,
  input  logic                                in_range_i,
  input  logic signed [arc_pkg::SampleW-1:0]  sample_i,
  input  logic [arc_pkg::TimeW-1:0]           now_ms_i,
  input  arc_pkg::chan_t                      ent_i,
  output logic                                upd_o,
  output arc_pkg::chan_t                      ent_o,
  output logic signed [arc_pkg::SampleW-1:0]  corrected_o,
  output logic                                probing_o
);

  logic                               active;
  logic                               same;
  logic [arc_pkg::SampleW:0]          mag;
  logic [arc_pkg::TimeW-1:0]          elapsed;
  logic signed [arc_pkg::SampleW:0]   diff;
  logic signed [arc_pkg::SampleW-1:0] sat;

  // calibration runs only when enabled and before the window end
  assign active = cfg_i.enable && (now_ms_i < cfg_i.window_end_ms);
  assign upd_o  = in_range_i && active;
  assign same   = (sample_i == ent_i.last_sample);

  // 17-bit magnitude so that full negative scale never qualifies
  assign mag     = sample_i[arc_pkg::SampleW-1] ?
                   (({arc_pkg::SampleW+1{1'b0}}) - {sample_i[arc_pkg::SampleW-1], sample_i}) :
                   {1'b0, sample_i};
  assign elapsed = now_ms_i - ent_i.probe_start;

  // state update
  always_comb begin
    ent_o = ent_i;
    if (!ent_i.probe_flag) begin
      if (same && (sample_i != ent_i.rest_offset) &&
          (mag < {2'b00, cfg_i.magnitude_limit})) begin
        ent_o.probe_flag  = 1'b1;
        ent_o.probe_start = now_ms_i;
      end
      ent_o.last_sample = sample_i;
    end else if (same) begin
      if (elapsed >= {16'd0, cfg_i.settle_time_ms}) begin
        ent_o.probe_flag  = 1'b0;
        ent_o.rest_offset = sample_i;
      end
    end else begin
      ent_o.probe_flag  = 1'b0;
      ent_o.last_sample = sample_i;
    end
  end

  // subtract the updated offset and saturate
  assign diff = {sample_i[arc_pkg::SampleW-1], sample_i} -
                {ent_o.rest_offset[arc_pkg::SampleW-1], ent_o.rest_offset};
  always_comb begin
    if (diff[arc_pkg::SampleW] != diff[arc_pkg::SampleW-1]) begin
      sat = diff[arc_pkg::SampleW] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      sat = diff[arc_pkg::SampleW-1:0];
    end
  end

  // result selection
  always_comb begin
    if (!in_range_i) begin
      corrected_o = sample_i;
      probing_o   = 1'b0;
    end else if (!active) begin
      corrected_o = sample_i;
      probing_o   = ent_i.probe_flag;
    end else begin
      corrected_o = sat;
      probing_o   = ent_o.probe_flag;
    end
  end

endmodule

// ===== rtl/axis_rest_offset_calibrator.sv =====
// top level of the per-channel axis rest offset calibrator
//
//  port group   direction  handshake               payload
//  in           input      in_valid_i / in_ready_o   channel_i, sample_i, now_ms_i
//  out          output     out_valid_o / out_ready_i corrected_o, probing_o
//  apb          input      psel/penable, pready=1    paddr, pwdata, prdata
//
// one transfer per cycle sustained while the output is not stalled; an input
// transfer reaches the result through an input register then a result register
// the per-channel state is read and written back in the cycle an item moves from
// the input register to the result register, so the next item sees the update
// a stalled output holds its result and the input register still takes one more
// item; reset clears all channel state and loads the register defaults
module axis_rest_offset_calibrator #(
  parameter int unsigned CHANNELS = arc_pkg::ChannelsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [arc_pkg::ChanW-1:0]           channel_i,
  input  logic signed [arc_pkg::SampleW-1:0]  sample_i,
  input  logic [arc_pkg::TimeW-1:0]           now_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [arc_pkg::SampleW-1:0]  corrected_o,
  output logic                                probing_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [arc_pkg::AddrW-1:0]           paddr,
  input  logic [arc_pkg::DataW-1:0]           pwdata,
  output logic [arc_pkg::DataW-1:0]           prdata,
  output logic                                pready
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  arc_pkg::cfg_t cfg;

  // input register
  logic                               in_vld_q;
  logic [arc_pkg::ChanW-1:0]          in_chan_q;
  logic signed [arc_pkg::SampleW-1:0] in_sample_q;
  logic [arc_pkg::TimeW-1:0]          in_now_q;

  // result register
  logic                               out_vld_q;
  logic signed [arc_pkg::SampleW-1:0] out_corr_q;
  logic                               out_prob_q;

  logic                               out_free;
  logic                               advance;
  logic                               in_range;
  logic [IdxW+arc_pkg::ChanW-1:0]     ch_ext;
  logic [IdxW-1:0]                    idx;
  arc_pkg::chan_t                     ent_rd;
  arc_pkg::chan_t                     ent_wr;
  logic                               upd;
  logic signed [arc_pkg::SampleW-1:0] corr;
  logic                               prob;

  arc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pipeline flow control
  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  // channel lookup
  assign in_range = ({{(arc_pkg::ChCmpW-arc_pkg::ChanW){1'b0}}, in_chan_q} <
                     arc_pkg::ChCmpW'(CHANNELS));
  assign ch_ext   = {{IdxW{1'b0}}, in_chan_q};
  assign idx      = in_range ? ch_ext[IdxW-1:0] : '0;

  arc_chan_state #(
    .CHANNELS (CHANNELS)
  ) u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (idx),
    .rd_data_o (ent_rd),
    .wr_en_i   (advance && upd),
    .wr_idx_i  (idx),
    .wr_data_i (ent_wr)
  );

  arc_calc u_calc (
    .cfg_i       (cfg),
    .in_range_i  (in_range),
    .sample_i    (in_sample_q),
    .now_ms_i    (in_now_q),
    .ent_i       (ent_rd),
    .upd_o       (upd),
    .ent_o       (ent_wr),
    .corrected_o (corr),
    .probing_o   (prob)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_chan_q   <= channel_i;
      in_sample_q <= sample_i;
      in_now_q    <= now_ms_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_corr_q <= corr;
      out_prob_q <= prob;
    end
  end

  assign out_valid_o = out_vld_q;
  assign corrected_o = out_corr_q;
  assign probing_o   = out_prob_q;

endmodule

// ===== rtl/arc_checker.sv =====
// port-level checks for the calibrator, bound to the top level
module arc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [arc_pkg::SampleW-1:0] corrected_o,
  input logic                               probing_o,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [arc_pkg::AddrW-1:0]          paddr,
  input logic [arc_pkg::DataW-1:0]          pwdata,
  input logic [arc_pkg::DataW-1:0]          prdata
);

  // input side only backs up when both registers hold items and output stalls
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("in_ready low without a stalled full pipeline");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(corrected_o) && $stable(probing_o)))
    else $error("result changed while stalled");

  // window end register reads back what was written
  a_window_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni) && $past(psel && penable && pwrite) &&
     ($past(paddr[arc_pkg::AddrW-1:2]) == arc_pkg::REG_WINDOW_END) &&
     (paddr[arc_pkg::AddrW-1:2] == arc_pkg::REG_WINDOW_END)) |->
      (prdata == $past(pwdata)))
    else $error("window end readback mismatch");

endmodule

bind axis_rest_offset_calibrator arc_checker u_arc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .corrected_o (corrected_o),
  .probing_o   (probing_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);
